// ----- design/pbwd_pkg.sv -----
package pbwd_pkg;

  // Number of controller register words.
  localparam int unsigned REG_WORDS = 31;
  localparam int unsigned RegIdxW   = $clog2(REG_WORDS);

  // Register word indices.
  localparam logic [4:0] IDX_BMCR    = 5'd0;
  localparam logic [4:0] IDX_SIMM1   = 5'd1;
  localparam logic [4:0] IDX_PCIMW1  = 5'd5;
  localparam logic [4:0] IDX_PCIMW2  = 5'd6;
  localparam logic [4:0] IDX_PCITW1  = 5'd7;
  localparam logic [4:0] IDX_PCITW2  = 5'd8;
  localparam logic [4:0] IDX_PCICAR  = 5'd9;
  localparam logic [4:0] IDX_PCICDR  = 5'd10;
  localparam logic [4:0] IDX_PCIMIOW = 5'd11;

  // Fixed CPU map.
  localparam logic [31:0] RomLo  = 32'h1fc0_0000;
  localparam logic [31:0] RomHi  = 32'h1fcf_ffff;
  localparam logic [31:0] RegsLo = 32'h0f00_0000;
  localparam logic [31:0] RegsHi = 32'(64'h0f00_0000 + 64'(REG_WORDS) * 64'd4 - 64'd1);
  localparam logic [31:0] CfgLo  = 32'h0f00_0100;
  localparam logic [31:0] CfgHi  = 32'h0f00_01ff;

  // Window masks.
  localparam logic [31:0] MstStartMask = 32'hff00_0000;
  localparam logic [31:0] MstTop       = 32'h8000_0000;
  localparam logic [31:0] TgtStartMask = 32'hffe0_0000;
  localparam logic [31:0] TgtTop       = 32'hf000_0000;
  localparam logic [31:0] DramBaseMask = 32'h0fc0_0000;
  localparam logic [31:0] SimmBaseMask = 32'h0fe0_0000;

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_CPU_DECODE = 2'd2,
    CMD_PCI_DECODE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    REGION_NONE    = 4'd0,
    REGION_ROM     = 4'd1,
    REGION_REGS    = 4'd2,
    REGION_CONFIG  = 4'd3,
    REGION_DRAM    = 4'd4,
    REGION_SIMM    = 4'd5,
    REGION_MEMWIN1 = 4'd6,
    REGION_MEMWIN2 = 4'd7,
    REGION_IO      = 4'd8,
    REGION_TARGET1 = 4'd9,
    REGION_TARGET2 = 4'd10
  } region_e;

  // Register file contents that the decoder looks at.
  typedef struct packed {
    logic [31:0] bmcr;
    logic [31:0] simm1;
    logic [31:0] pcimw1;
    logic [31:0] pcimw2;
    logic [31:0] pcimiow;
    logic [31:0] pcitw1;
    logic [31:0] pcitw2;
    logic [31:0] dram_base;
    logic [1:0]  dram_shift;
    logic [31:0] bank1_base;
    logic [2:0]  simm_shift;
  } state_t;

endpackage

// ----- design/pbwd_regfile.sv -----
module pbwd_regfile (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [4:0]           idx_i,
  input  logic [31:0]          wr_data_i,
  input  logic [3:0]           wr_be_i,
  output logic [31:0]          rd_data_o,
  output pbwd_pkg::state_t     state_o
);

  logic [31:0] rf_q [pbwd_pkg::REG_WORDS];
  logic [31:0] rf_d [pbwd_pkg::REG_WORDS];
  logic [31:0] cfg_addr_q, cfg_addr_d;
  logic [31:0] dram_base_q, dram_base_d;
  logic [1:0]  dram_shift_q, dram_shift_d;
  logic [31:0] bank1_base_q, bank1_base_d;
  logic [2:0]  simm_shift_q, simm_shift_d;

  logic                            idx_ok;
  logic [pbwd_pkg::RegIdxW-1:0]    ridx;
  logic [31:0]                     old_word;
  logic [31:0]                     mask;
  logic [31:0]                     merged;

  // Rewrites a type-0 configuration address as type 1; the lowest set bit of
  // 23..11 gives the device number.
  function automatic logic [31:0] to_type1(input logic [31:0] v);
    logic [3:0] dev;
    dev = 4'd0;
    for (int i = 23; i >= 11; i--) begin
      if (v[i]) dev = 4'(i - 10);
    end
    if (v[1:0] != 2'b00) return v;
    return {1'b1, 16'b0, dev, v[10:0]};
  endfunction

  assign idx_ok   = 32'(idx_i) < pbwd_pkg::REG_WORDS;
  assign ridx     = pbwd_pkg::RegIdxW'(idx_i);
  assign old_word = idx_ok ? rf_q[ridx] : 32'd0;
  assign mask     = {{8{wr_be_i[3]}}, {8{wr_be_i[2]}}, {8{wr_be_i[1]}}, {8{wr_be_i[0]}}};
  assign merged   = (old_word & ~mask) | (wr_data_i & mask);

  always_comb begin
    rf_d         = rf_q;
    cfg_addr_d   = cfg_addr_q;
    dram_base_d  = dram_base_q;
    dram_shift_d = dram_shift_q;
    bank1_base_d = bank1_base_q;
    simm_shift_d = simm_shift_q;
    if (wr_en_i && idx_ok) begin
      rf_d[ridx] = merged;
      case (idx_i)
        pbwd_pkg::IDX_PCICAR: cfg_addr_d = to_type1(merged);
        pbwd_pkg::IDX_BMCR: begin
          if (merged[3]) begin
            dram_base_d  = merged & pbwd_pkg::DramBaseMask;
            dram_shift_d = merged[14] ? 2'd0 : (merged[15] ? 2'd1 : 2'd2);
          end
        end
        pbwd_pkg::IDX_SIMM1: begin
          if (merged[3]) begin
            bank1_base_d = merged & pbwd_pkg::SimmBaseMask;
            simm_shift_d = 3'd5;
            for (int i = 17; i >= 13; i--) begin
              if (merged[i]) simm_shift_d = 3'(i - 13);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pbwd_pkg::REG_WORDS; i++) rf_q[i] <= 32'd0;
      cfg_addr_q   <= 32'd0;
      dram_base_q  <= 32'd0;
      dram_shift_q <= 2'd0;
      bank1_base_q <= 32'd0;
      simm_shift_q <= 3'd0;
    end else begin
      rf_q         <= rf_d;
      cfg_addr_q   <= cfg_addr_d;
      dram_base_q  <= dram_base_d;
      dram_shift_q <= dram_shift_d;
      bank1_base_q <= bank1_base_d;
      simm_shift_q <= simm_shift_d;
    end
  end

  // The address register reads back the converted address; the data
  // register reads back what was stored.
  always_comb begin
    if (idx_i == pbwd_pkg::IDX_PCICAR) begin
      rd_data_o = cfg_addr_q;
    end else begin
      rd_data_o = old_word;
    end
  end

  assign state_o.bmcr       = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_BMCR)];
  assign state_o.simm1      = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_SIMM1)];
  assign state_o.pcimw1     = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_PCIMW1)];
  assign state_o.pcimw2     = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_PCIMW2)];
  assign state_o.pcimiow    = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_PCIMIOW)];
  assign state_o.pcitw1     = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_PCITW1)];
  assign state_o.pcitw2     = rf_q[pbwd_pkg::RegIdxW'(pbwd_pkg::IDX_PCITW2)];
  assign state_o.dram_base  = dram_base_q;
  assign state_o.dram_shift = dram_shift_q;
  assign state_o.bank1_base = bank1_base_q;
  assign state_o.simm_shift = simm_shift_q;

endmodule

// ----- design/pbwd_decode.sv -----
module pbwd_decode (
  input  pbwd_pkg::cmd_e     cmd_i,
  input  logic [31:0]        addr_i,
  input  pbwd_pkg::state_t   state_i,
  output pbwd_pkg::region_e  region_o,
  output logic [31:0]        xaddr_o
);

  // Returns {hit, offset into window}. Set bits of the size field add compared
  // bits just below the top bits, which are always compared, and narrow the window.
  function automatic logic [32:0] win_check(input logic [31:0] r,
                                            input logic [31:0] start_mask,
                                            input logic [31:0] top,
                                            input int unsigned pos,
                                            input logic [31:0] a);
    logic [31:0] st;
    logic [31:0] en;
    st = r & start_mask;
    en = st | ~(top | ({25'b0, r[19:13]} << pos));
    return {r[12] && (a >= st) && (a <= en), a - st};
  endfunction

  logic [32:0] dram_diff, simm_diff, dram_size, bank1_span;
  logic        dram_hit, simm_hit;
  logic [32:0] mw1, mw2, mio, tw1, tw2;

  assign dram_size  = 33'b1 << (6'd22 + 6'(state_i.dram_shift));
  assign bank1_span = 33'b1 << (6'd21 + 6'(state_i.simm_shift));
  assign dram_diff  = {1'b0, addr_i} - {1'b0, state_i.dram_base};
  assign simm_diff  = {1'b0, addr_i} - {1'b0, state_i.bank1_base};
  assign dram_hit   = state_i.bmcr[3] && !dram_diff[32] && (dram_diff < dram_size);
  assign simm_hit   = state_i.simm1[3] && !simm_diff[32] && (simm_diff < bank1_span);

  assign mw1 = win_check(state_i.pcimw1, pbwd_pkg::MstStartMask, pbwd_pkg::MstTop, 24, addr_i);
  assign mw2 = win_check(state_i.pcimw2, pbwd_pkg::MstStartMask, pbwd_pkg::MstTop, 24, addr_i);
  assign mio = win_check(state_i.pcimiow, pbwd_pkg::MstStartMask, pbwd_pkg::MstTop, 24, addr_i);
  assign tw1 = win_check(state_i.pcitw1, pbwd_pkg::TgtStartMask, pbwd_pkg::TgtTop, 21, addr_i);
  assign tw2 = win_check(state_i.pcitw2, pbwd_pkg::TgtStartMask, pbwd_pkg::TgtTop, 21, addr_i);

  // Later checks override earlier ones, so the last hit wins.
  always_comb begin
    region_o = pbwd_pkg::REGION_NONE;
    xaddr_o  = 32'd0;
    case (cmd_i)
      pbwd_pkg::CMD_CPU_DECODE: begin
        if (addr_i >= pbwd_pkg::RomLo && addr_i <= pbwd_pkg::RomHi) begin
          region_o = pbwd_pkg::REGION_ROM;
          xaddr_o  = addr_i - pbwd_pkg::RomLo;
        end
        if (addr_i >= pbwd_pkg::RegsLo && addr_i <= pbwd_pkg::RegsHi) begin
          region_o = pbwd_pkg::REGION_REGS;
          xaddr_o  = addr_i - pbwd_pkg::RegsLo;
        end
        if (addr_i >= pbwd_pkg::CfgLo && addr_i <= pbwd_pkg::CfgHi) begin
          region_o = pbwd_pkg::REGION_CONFIG;
          xaddr_o  = addr_i - pbwd_pkg::CfgLo;
        end
        if (dram_hit) begin
          region_o = pbwd_pkg::REGION_DRAM;
          xaddr_o  = dram_diff[31:0];
        end
        if (simm_hit) begin
          region_o = pbwd_pkg::REGION_SIMM;
          xaddr_o  = simm_diff[31:0];
        end
        if (mw1[32]) begin
          region_o = pbwd_pkg::REGION_MEMWIN1;
          xaddr_o  = {state_i.pcimw1[7:0], 24'b0} | mw1[31:0];
        end
        if (mw2[32]) begin
          region_o = pbwd_pkg::REGION_MEMWIN2;
          xaddr_o  = {state_i.pcimw2[7:0], 24'b0} | mw2[31:0];
        end
        if (mio[32]) begin
          region_o = pbwd_pkg::REGION_IO;
          xaddr_o  = {state_i.pcimiow[7:0], 24'b0} | mio[31:0];
        end
      end
      pbwd_pkg::CMD_PCI_DECODE: begin
        if (tw1[32]) begin
          region_o = pbwd_pkg::REGION_TARGET1;
          xaddr_o  = {state_i.pcitw1[10:0], 21'b0} | tw1[31:0];
        end
        if (tw2[32]) begin
          region_o = pbwd_pkg::REGION_TARGET2;
          xaddr_o  = {state_i.pcitw2[10:0], 21'b0} | tw2[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/pci_bridge_window_decoder.sv -----
// Register file and address window decoder of a CPU-to-PCI bridge.
// Each input word carries a command: a byte-masked register write, a
// register read, a CPU-address decode or a PCI-address decode. Each accepted
// word gives exactly one result word with read data, region and translated
// address; fields that the command does not produce are zero.
// Both channels use valid/ready. A word is captured in an input register,
// then decoded against the register state and written to the result
// register once the result register is free, that is, empty or being
// taken by the receiver.
// Throughput is one word per cycle while the receiver takes each result; the
// single decode stage between the input and result registers sets it, and register
// writes update the state as the word leaves the input register, so the next word already sees them.
// When the receiver stalls, the result register holds and the input
// register fills; ready falls only once both are occupied.
// Reset clears all registers, the derived window state and both pipeline
// stages; the block is ready for a word as soon as reset is released.
module pci_bridge_window_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [3:0]  byte_enable_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [3:0]  region_o,
  output logic [31:0] translated_address_o
);

  logic               s1_valid_q, s1_valid_d;
  pbwd_pkg::cmd_e     cmd_q;
  logic [4:0]         idx_q;
  logic [31:0]        data_q;
  logic [3:0]         be_q;
  logic [31:0]        addr_q;

  logic               out_valid_q, out_valid_d;
  logic [31:0]        rd_q;
  pbwd_pkg::region_e  region_q;
  logic [31:0]        xaddr_q;

  logic               out_free, advance, in_fire;
  logic [31:0]        rf_rd;
  pbwd_pkg::state_t   state;
  pbwd_pkg::region_e  dec_region;
  logic [31:0]        dec_xaddr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  pbwd_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (advance && cmd_q == pbwd_pkg::CMD_WRITE),
    .idx_i     (idx_q),
    .wr_data_i (data_q),
    .wr_be_i   (be_q),
    .rd_data_o (rf_rd),
    .state_o   (state)
  );

  pbwd_decode u_decode (
    .cmd_i    (cmd_q),
    .addr_i   (addr_q),
    .state_i  (state),
    .region_o (dec_region),
    .xaddr_o  (dec_xaddr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= pbwd_pkg::cmd_e'(command_i);
      idx_q  <= reg_index_i;
      data_q <= write_data_i;
      be_q   <= byte_enable_i;
      addr_q <= address_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q     <= (cmd_q == pbwd_pkg::CMD_READ) ? rf_rd : 32'd0;
      region_q <= dec_region;
      xaddr_q  <= dec_xaddr;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = rd_q;
  assign region_o             = region_q;
  assign translated_address_o = xaddr_q;

  a_ready_low_needs_full_stage: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while the pipeline can move");

  a_advance_fills_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced word did not reach the result register");

  a_read_excludes_region: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_data_o != 32'd0 |-> region_o == pbwd_pkg::REGION_NONE)
    else $error("read data and a decode region in the same result");

  a_no_hit_no_address: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o == pbwd_pkg::REGION_NONE |-> translated_address_o == 32'd0)
    else $error("translated address without a hit");

endmodule
